FILE: hdl/stmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmt_pkg: shared constants for the successor take minimum tree
// Default universe size, value width and the reset value of the limit.
// ----------------------------------------------------------------------------
package stmt_pkg;

    // Default number of values in the universe (values 1 to MAX_VALUE).
    localparam int MAX_VALUE_DEFAULT = 4096;

    // Width that holds every value plus the empty mark MAX_VALUE + 1.
    localparam int VALUE_W_DEFAULT = $clog2(MAX_VALUE_DEFAULT + 2);

    // Limit register value after reset.
    localparam int LIMIT_RESET = 4096;

endpackage : stmt_pkg
`default_nettype wire

FILE: hdl/stmt_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmt_item_if: request channel of the successor take minimum tree
// Carries one insert or take request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stmt_item_if
    import stmt_pkg::*;
#(
    parameter int VW = VALUE_W_DEFAULT
) ();

    logic          valid;
    logic          ready;
    logic          func;
    logic [VW-1:0] item_value;

    modport source (output valid, output func, output item_value, input ready);
    modport sink   (input valid, input func, input item_value, output ready);

endinterface : stmt_item_if
`default_nettype wire

FILE: hdl/stmt_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmt_result_if: result channel of the successor take minimum tree
// Carries the outcome of one take request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stmt_result_if
    import stmt_pkg::*;
#(
    parameter int VW = VALUE_W_DEFAULT
) ();

    logic          valid;
    logic          ready;
    logic          found;
    logic [VW-1:0] taken_value;

    modport source (output valid, output found, output taken_value, input ready);
    modport sink   (input valid, input found, input taken_value, output ready);

endinterface : stmt_result_if
`default_nettype wire

FILE: hdl/successor_take_min_tree.sv
// Insert: writes the leaf, then the minima up to the root; L = clog2(MAX_VALUE).
// Take: the search reads one node per level, then the result is registered; a hit then
// rewrites the leaf-to-root path, writing one node per level.
// One request is in flight at a time; a waiting result stalls only the result step of a take.
// After reset a clearing pass writes the empty mark to all 2^(L+1) tree nodes
// before the first request is accepted.
`default_nettype none
// ----------------------------------------------------------------------------
// successor_take_min_tree: set of values kept as a binary tree of minima
// Insert marks a value present; take returns and removes the smallest present
// value above a threshold and not above the configured limit.
// ----------------------------------------------------------------------------
module successor_take_min_tree
    import stmt_pkg::*;
#(
    parameter int MAX_VALUE = MAX_VALUE_DEFAULT,
    parameter int VW        = $clog2(MAX_VALUE + 2)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [VW-1:0] cfg_wdata,
    stmt_item_if.sink          items,
    stmt_result_if.source      results
);

    // Tree geometry: leaves at depth L, heap addressing with the root at node 1.
    localparam int L  = $clog2(MAX_VALUE);
    localparam int AW = L + 1;
    localparam int SW = $clog2(L + 1);
    localparam int DEPTH = 1 << AW;
    localparam int LIMIT_RST = (LIMIT_RESET < MAX_VALUE) ? LIMIT_RESET : MAX_VALUE;

    localparam logic [VW-1:0] EMPTY_MARK = VW'(MAX_VALUE + 1);
    localparam logic [VW-1:0] MAX_V      = VW'(MAX_VALUE);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_RESULT = 7'b0010000,
        ST_LEAF   = 7'b0100000,
        ST_UP     = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [VW-1:0]  limit_reg, limit_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [AW-1:0]  node_reg, node_next;
    logic [L-1:0]   path_reg, path_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           cand_reg, cand_next;
    logic [VW-1:0]  best_reg, best_next;
    logic [VW-1:0]  w_reg, w_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_found_reg, out_found_next;
    logic [VW-1:0]  out_value_reg, out_value_next;

    // Tree memory: one write and one registered read per cycle.
    logic [VW-1:0]  tree_mem [DEPTH];
    logic [VW-1:0]  rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [VW-1:0]  mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    logic [VW-1:0]  lim;
    logic           hit;
    logic [AW-1:0]  child;
    logic [AW-1:0]  parent_addr;
    logic [VW-1:0]  parent_min;
    logic [VW-1:0]  ins_m1;
    logic [VW-1:0]  best_m1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= tree_mem[mem_raddr];
        end
    end

    // Limit in use, saturated to the universe.
    assign lim = (limit_reg > MAX_V) ? MAX_V : limit_reg;

    // The search found a value if the best candidate does not exceed the limit.
    assign hit = (best_reg <= lim);

    // Next node on the search path and the parent on the way up.
    assign child       = {node_reg[AW-2:0], path_reg[L-1]};
    assign parent_addr = node_reg >> 1;
    assign parent_min  = (rd_data_reg < w_reg) ? rd_data_reg : w_reg;
    assign ins_m1      = items.item_value - 1'b1;
    assign best_m1     = best_reg - 1'b1;

    assign items.ready         = (state_reg == ST_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.found       = out_found_reg;
    assign results.taken_value = out_value_reg;

    // Sequencer: search down the path, then rewrite minima from leaf to root.
    // Within one request a read never targets the node written in the same
    // cycle, so no forwarding is needed.
    always_comb
    begin
        state_next     = state_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        path_next      = path_reg;
        step_next      = step_reg;
        cand_next      = 1'b0;
        best_next      = best_reg;
        w_next         = w_reg;
        out_valid_next = out_valid_reg & ~results.ready;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = w_reg;
        mem_re         = 1'b0;
        mem_raddr      = node_reg;

        // Fold in the candidate read of the previous cycle.
        if (cand_reg && (rd_data_reg < best_reg))
        begin
            best_next = rd_data_reg;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = EMPTY_MARK;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (items.valid)
                begin
                    if (!items.func)
                    begin
                        // Insert: out-of-range values are dropped.
                        if ((items.item_value != '0) && (items.item_value <= lim))
                        begin
                            node_next  = {1'b1, ins_m1[L-1:0]};
                            w_next     = items.item_value;
                            state_next = ST_LEAF;
                        end
                    end
                    else
                    begin
                        best_next = EMPTY_MARK;
                        if (items.item_value < lim)
                        begin
                            node_next  = AW'(1);
                            path_next  = items.item_value[L-1:0];
                            step_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                mem_re = 1'b1;
                if (step_reg == SW'(L))
                begin
                    // The leaf of the value just above the threshold is the last candidate.
                    mem_raddr  = node_reg;
                    cand_next  = 1'b1;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    // A right sibling of a left turn covers only larger values.
                    mem_raddr = child | AW'(1);
                    cand_next = ~path_reg[L-1];
                    node_next = child;
                    path_next = path_reg << 1;
                    step_next = step_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit;
                    out_value_next = hit ? best_reg : '0;
                    if (hit)
                    begin
                        node_next  = {1'b1, best_m1[L-1:0]};
                        w_next     = EMPTY_MARK;
                        state_next = ST_LEAF;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LEAF:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg;
                mem_wdata  = w_reg;
                mem_re     = 1'b1;
                mem_raddr  = node_reg ^ AW'(1);
                state_next = ST_UP;
            end

            ST_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent_addr;
                mem_wdata = parent_min;
                w_next    = parent_min;
                node_next = parent_addr;
                if (parent_addr == AW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_addr ^ AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            limit_reg     <= VW'(LIMIT_RST);
            clr_reg       <= '0;
            step_reg      <= '0;
            cand_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        path_reg      <= path_next;
        best_reg      <= best_next;
        w_reg         <= w_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
    end

endmodule : successor_take_min_tree
`default_nettype wire
